[design/rch_pkg.sv]
// ----------------------------------------------------------------------------
// rch_pkg
// Shared widths, transaction codes and defaults for the RGB color histogram.
// ----------------------------------------------------------------------------
package rch_pkg;

    localparam int CH_BITS        = 8;
    localparam int KIND_BITS      = 2;
    localparam int BIN_BITS       = 9;
    localparam int LEVEL_BITS     = 9;
    localparam int CFG_BITS       = 2;
    localparam int CFG_IDX_BITS   = 2;
    localparam int LEVEL_STEPS    = 9;
    localparam int INDEX_BITS_DEF = 9;
    localparam int COUNT_BITS_DEF = 24;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(256);

    localparam logic [KIND_BITS-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_NONE  = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RED   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GREEN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLUE  = 2'd2;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 2'd3;

endpackage

[design/rgb_color_histogram_top.sv]
// ----------------------------------------------------------------------------
// rgb_color_histogram_top
// Quantized RGB color histogram with saturating bin counts and peak tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. i_kind selects pixel count, bin level read or clear.
//   Pixel: the top configured bits of red, green and blue form the bin; the
//   bin count is read, bumped (saturating) and written back, and the peak is
//   updated. busy stays high through the read and write-back states.
//   Read: returns floor(count*256/peak), or 0 for a zero peak, on o_level
//   with o_level_valid high for one cycle once the division ends; busy stays
//   high through the read, load and divide states. The quotient comes from
//   one compare/subtract unit, one bit per cycle.
//   Clear: zeroes the peak and sweeps the count memory one entry per cycle,
//   with busy high until the sweep ends. The same sweep runs after reset.
//   Configuration writes go through i_cfg_we at any time; index 3 is dropped.
//   The result strobe cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module rgb_color_histogram_top #(
    parameter int INDEX_BITS = rch_pkg::INDEX_BITS_DEF,
    parameter int COUNT_BITS = rch_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rch_pkg::KIND_BITS-1:0] i_kind,
    input  logic [rch_pkg::CH_BITS-1:0]   i_red,
    input  logic [rch_pkg::CH_BITS-1:0]   i_green,
    input  logic [rch_pkg::CH_BITS-1:0]   i_blue,
    input  logic [rch_pkg::BIN_BITS-1:0]  i_bin,
    output logic                          o_level_valid,
    output logic [rch_pkg::LEVEL_BITS-1:0] o_level,
    input  logic                          i_cfg_we,
    input  logic [rch_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [rch_pkg::CFG_BITS-1:0]  i_cfg_wdata
);
    import rch_pkg::*;

    localparam int DEPTH     = 1 << INDEX_BITS;
    localparam int STEP_BITS = $clog2(LEVEL_STEPS);
    localparam int EXT_BITS  = BIN_BITS + INDEX_BITS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLEAR  = 7'b0000010,
        S_PIX_RD = 7'b0000100,
        S_PIX_WR = 7'b0001000,
        S_RD_RD  = 7'b0010000,
        S_LOAD   = 7'b0100000,
        S_DIV    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_BITS-1:0]   r_red_bits, r_green_bits, r_blue_bits;
    logic [INDEX_BITS-1:0] r_addr, n_addr;
    logic [COUNT_BITS-1:0] r_peak, n_peak;
    logic [COUNT_BITS:0]   r_rem, n_rem;
    logic [LEVEL_BITS-1:0] r_quo, n_quo;
    logic [STEP_BITS-1:0]  r_step, n_step;
    logic                  r_valid, n_valid;
    logic [LEVEL_BITS-1:0] r_level, n_level;
    logic [COUNT_BITS-1:0] r_rdata;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic                  mem_we;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic [BIN_BITS-1:0]   red_top, green_top, blue_top, pix_bin;
    logic [2:0]            gb_shift;
    logic [EXT_BITS-1:0]   pix_ext, bin_ext;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS:0]   div_diff, div_keep;
    logic                  div_ge;

    // bin index from pixel
    always_comb begin
        red_top   = {1'b0, i_red}   >> (4'd8 - {2'b00, r_red_bits});
        green_top = {1'b0, i_green} >> (4'd8 - {2'b00, r_green_bits});
        blue_top  = {1'b0, i_blue}  >> (4'd8 - {2'b00, r_blue_bits});
        gb_shift  = {1'b0, r_green_bits} + {1'b0, r_blue_bits};
        pix_bin   = (red_top << gb_shift) | (green_top << r_blue_bits) | blue_top;
        pix_ext   = {{INDEX_BITS{1'b0}}, pix_bin};
        bin_ext   = {{INDEX_BITS{1'b0}}, i_bin};
    end

    // compare/subtract unit and saturating count increment
    always_comb begin
        div_diff = r_rem - {1'b0, r_peak};
        div_ge   = (r_rem >= {1'b0, r_peak});
        div_keep = div_ge ? div_diff : r_rem;
        cnt_inc  = (r_rdata != {COUNT_BITS{1'b1}}) ? r_rdata + 1'b1 : r_rdata;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_peak    = r_peak;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_step    = r_step;
        n_valid   = 1'b0;
        n_level   = r_level;
        mem_we    = 1'b0;
        mem_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_kind)
                        KIND_PIXEL: begin
                            n_addr  = pix_ext[INDEX_BITS-1:0];
                            n_state = S_PIX_RD;
                        end
                        KIND_READ: begin
                            n_addr  = bin_ext[INDEX_BITS-1:0];
                            n_state = S_RD_RD;
                        end
                        KIND_CLEAR: begin
                            n_addr  = '0;
                            n_peak  = '0;
                            n_state = S_CLEAR;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == {INDEX_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_PIX_RD: n_state = S_PIX_WR;
            S_PIX_WR: begin
                mem_we    = 1'b1;
                mem_wdata = cnt_inc;
                if (cnt_inc > r_peak) begin
                    n_peak = cnt_inc;
                end
                n_state = S_IDLE;
            end
            S_RD_RD: n_state = S_LOAD;
            S_LOAD: begin
                n_rem   = {1'b0, r_rdata};
                n_quo   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo  = {r_quo[LEVEL_BITS-2:0], div_ge};
                n_rem  = {div_keep[COUNT_BITS-1:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == STEP_BITS'(LEVEL_STEPS - 1)) begin
                    n_valid = 1'b1;
                    n_level = (r_peak == '0) ? '0 : n_quo;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_peak       <= '0;
            r_step       <= '0;
            r_valid      <= 1'b0;
            r_red_bits   <= CFG_RESET;
            r_green_bits <= CFG_RESET;
            r_blue_bits  <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_peak  <= n_peak;
            r_step  <= n_step;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RED:   r_red_bits   <= i_cfg_wdata;
                    CFG_GREEN: r_green_bits <= i_cfg_wdata;
                    CFG_BLUE:  r_blue_bits  <= i_cfg_wdata;
                    default:   r_red_bits   <= r_red_bits;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_level <= n_level;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    assign busy          = (r_state != S_IDLE);
    assign o_level_valid = r_valid;
    assign o_level       = r_level;

endmodule

[design/rch_checker.sv]
// ----------------------------------------------------------------------------
// rch_checker
// Port-level checks of the RGB color histogram, bound to the top level.
// ----------------------------------------------------------------------------
module rch_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [rch_pkg::KIND_BITS-1:0]  i_kind,
    input logic                           o_level_valid,
    input logic [rch_pkg::LEVEL_BITS-1:0] o_level
);
    import rch_pkg::*;

    a_reset_sweep: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("no clear sweep after reset");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_level_valid |-> (o_level <= LEVEL_MAX))
        else $error("level above 256");

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_level_valid |=> !o_level_valid)
        else $error("result strobe longer than one cycle");

    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_level_valid |-> !busy)
        else $error("result shown while busy");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind != KIND_NONE) |=> busy)
        else $error("transaction taken without going busy");

endmodule

bind rgb_color_histogram_top rch_checker u_rch_checker (.*);

[test/rgb_color_histogram_top_tb.sv]
// ----------------------------------------------------------------------------
// rgb_color_histogram_top_tb
// Self-checking bench for the RGB color histogram: pixel, read, clear and
// unused transactions go in through the command port under several channel
// bit settings, and each level strobe is checked against a predicted level.
// ----------------------------------------------------------------------------
module rgb_color_histogram_top_tb;
    import rch_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int BIN_DEPTH      = 1 << INDEX_BITS_DEF;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 105;
    localparam int PALETTE_SIZE   = 6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    class level_scoreboard;
        bit [COUNT_BITS_DEF-1:0] bin_counts [BIN_DEPTH];
        bit [COUNT_BITS_DEF-1:0] peak_count;
        bit [CFG_BITS-1:0]       red_bits;
        bit [CFG_BITS-1:0]       green_bits;
        bit [CFG_BITS-1:0]       blue_bits;
        logic [LEVEL_BITS-1:0]   pending_levels [$];
        int                      errors;

        function new();
            red_bits   = CFG_RESET;
            green_bits = CFG_RESET;
            blue_bits  = CFG_RESET;
            peak_count = '0;
            errors     = 0;
        endfunction

        task report_mismatch(string msg);
            $display("level check: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
            case (idx)
                CFG_RED:   red_bits   = val;
                CFG_GREEN: green_bits = val;
                CFG_BLUE:  blue_bits  = val;
                default: ;
            endcase
        endfunction

        function logic [BIN_BITS-1:0] bin_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned rb, gb, bb, idx;
            rb  = red_bits;
            gb  = green_bits;
            bb  = blue_bits;
            idx = ((int'(r) >> (CH_BITS - rb)) << (gb + bb))
                + ((int'(g) >> (CH_BITS - gb)) << bb)
                + (int'(b) >> (CH_BITS - bb));
            idx = idx & (BIN_DEPTH - 1);
            return idx[BIN_BITS-1:0];
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        function void note_transaction(logic [KIND_BITS-1:0] kind, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b,
                                       logic [BIN_BITS-1:0] bin);
            int unsigned     idx;
            longint unsigned level;
            case (kind)
                KIND_PIXEL: begin
                    idx = bin_of(r, g, b);
                    if (bin_counts[idx] != '1)
                        bin_counts[idx]++;
                    if (bin_counts[idx] > peak_count)
                        peak_count = bin_counts[idx];
                end
                KIND_READ: begin
                    idx   = int'(bin) & (BIN_DEPTH - 1);
                    level = 0;
                    if (peak_count != 0)
                        level = (longint'(bin_counts[idx]) * 256) / peak_count;
                    pending_levels.push_back(level[LEVEL_BITS-1:0]);
                end
                KIND_CLEAR: begin
                    foreach (bin_counts[i])
                        bin_counts[i] = '0;
                    peak_count = '0;
                end
                default: ;
            endcase
        endfunction

        task check_level(logic [LEVEL_BITS-1:0] level);
            logic [LEVEL_BITS-1:0] want;
            if (pending_levels.size() == 0) begin
                report_mismatch($sformatf("unexpected level %0d", level));
            end else begin
                want = pending_levels.pop_front();
                if (level !== want)
                    report_mismatch($sformatf("got %0d, expected %0d", level, want));
            end
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [KIND_BITS-1:0]    i_kind;
    logic [CH_BITS-1:0]      i_red;
    logic [CH_BITS-1:0]      i_green;
    logic [CH_BITS-1:0]      i_blue;
    logic [BIN_BITS-1:0]     i_bin;
    logic                    o_level_valid;
    logic [LEVEL_BITS-1:0]   o_level;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_wdata;

    level_scoreboard sb = new();
    logic [23:0]     palette [PALETTE_SIZE];
    int              idle_cycles;
    int              burst_left;

    rgb_color_histogram_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_bin         (i_bin),
        .o_level_valid (o_level_valid),
        .o_level       (o_level),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_level_valid)
            sb.check_level(o_level);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_level_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rgb_color_histogram_top: mismatch");
                $finish;
            end
        end
    end

    task automatic send(logic [KIND_BITS-1:0] kind, logic [7:0] r, logic [7:0] g,
                        logic [7:0] b, logic [BIN_BITS-1:0] bin);
        start   <= 1'b1;
        i_kind  <= kind;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        i_bin   <= bin;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_transaction(kind, r, g, b, bin);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // hold until every level is back and the block is quiet
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bins(logic [CFG_BITS-1:0] r, logic [CFG_BITS-1:0] g,
                            logic [CFG_BITS-1:0] b);
        logic [CFG_BITS-1:0] junk;
        junk = CFG_BITS'($urandom());
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_RED;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_GREEN;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_BLUE;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_UNUSED;
        i_cfg_wdata <= junk;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(CFG_RED, r);
        sb.write_reg(CFG_GREEN, g);
        sb.write_reg(CFG_BLUE, b);
        sb.write_reg(CFG_UNUSED, junk);
        @(posedge i_clk);
    endtask

    task automatic random_transaction();
        int                  roll;
        logic [23:0]         px;
        logic [BIN_BITS-1:0] bin;
        roll = $urandom_range(0, 99);
        px   = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, PALETTE_SIZE - 1)]
                                          : 24'($urandom());
        bin  = BIN_BITS'($urandom());
        if (burst_left == 0) begin
            pause($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (roll < 70) begin
            send(KIND_PIXEL, px[23:16], px[15:8], px[7:0], bin);
        end else if (roll < 92) begin
            if ($urandom_range(0, 9) < 6)
                bin = sb.bin_of(px[23:16], px[15:8], px[7:0]);
            send(KIND_READ, 8'($urandom()), 8'($urandom()), 8'($urandom()), bin);
        end else if (roll < 96) begin
            send(KIND_CLEAR, 8'($urandom()), 8'($urandom()), 8'($urandom()), bin);
        end else begin
            send(KIND_NONE, px[23:16], px[15:8], px[7:0], bin);
        end
    endtask

    initial begin
        logic [CFG_BITS-1:0] phase_bits [PHASES][3];
        logic [23:0]         px;
        phase_bits = '{'{2'd1, 2'd1, 2'd1}, '{2'd3, 2'd3, 2'd3}, '{2'd0, 2'd3, 2'd2},
                       '{2'd2, 2'd1, 2'd3}, '{2'd3, 2'd0, 2'd0}, '{2'd2, 2'd2, 2'd2}};
        burst_left  = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_kind      <= KIND_PIXEL;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_bin       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_RED;
        i_cfg_wdata <= CFG_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        // reset settings: peak zero, channel extremes, bit patterns, unused kind, clear
        send(KIND_READ, 8'h00, 8'h00, 8'h00, 9'd0);
        send(KIND_PIXEL, 8'h00, 8'h00, 8'h00, 9'h1FF);
        send(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 9'h000);
        send(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 9'h155);
        send(KIND_READ, 8'hFF, 8'hFF, 8'hFF, 9'h1FF);
        send(KIND_READ, 8'h00, 8'h00, 8'h00, 9'h000);
        send(KIND_READ, 8'h00, 8'h00, 8'h00, 9'h001);
        send(KIND_PIXEL, 8'hE0, 8'h1F, 8'hA5, 9'h0AA);
        send(KIND_PIXEL, 8'h1F, 8'hE0, 8'h5A, 9'h155);
        send(KIND_READ, 8'h00, 8'h00, 8'h00, sb.bin_of(8'hE0, 8'h1F, 8'hA5));
        send(KIND_NONE, 8'hFF, 8'hFF, 8'hFF, 9'h1FF);
        send(KIND_READ, 8'hAA, 8'h55, 8'hAA, 9'h000);
        send(KIND_CLEAR, 8'h00, 8'h00, 8'h00, 9'h000);
        send(KIND_READ, 8'h00, 8'h00, 8'h00, 9'h1FF);
        send(KIND_PIXEL, 8'h80, 8'h40, 8'h20, 9'h000);
        send(KIND_READ, 8'h00, 8'h00, 8'h00, sb.bin_of(8'h80, 8'h40, 8'h20));

        // all channels dropped from the index
        wait_drained();
        set_bins(2'd0, 2'd0, 2'd0);
        repeat (3) begin
            px = 24'($urandom());
            send(KIND_PIXEL, px[23:16], px[15:8], px[7:0], BIN_BITS'($urandom()));
        end
        send(KIND_READ, 8'h00, 8'h00, 8'h00, 9'h000);
        send(KIND_READ, 8'h00, 8'h00, 8'h00, 9'h100);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            set_bins(phase_bits[p][0], phase_bits[p][1], phase_bits[p][2]);
            foreach (palette[i])
                palette[i] = 24'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_transaction();
        end

        wait_drained();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d levels never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("rgb_color_histogram_top: match");
        else
            $display("rgb_color_histogram_top: mismatch");
        $finish;
    end

endmodule

[files.f]
design/rch_pkg.sv
design/rgb_color_histogram_top.sv
design/rch_checker.sv
test/rgb_color_histogram_top_tb.sv
